### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the wildcard key table.
// Needs signals clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset has been released.
`define WK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: when cond holds, prop must hold in the same cycle.
`define WK_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

### rtl/wkts_pkg.sv
// Types, constants and glob-match helpers for the wildcard key table.
// No dependencies.
`default_nettype none
package wkts_pkg;

  localparam int DEF_TABLE_DEPTH   = 64;
  localparam int DEF_KEY_CHARS     = 15;
  localparam int DEF_CHAR_MAP_SIZE = 256;

  localparam int STR_BYTES = 15;
  localparam int STR_W     = STR_BYTES * 8;
  localparam int PAT_BYTES = STR_BYTES + 1;
  localparam int PAT_W     = PAT_BYTES * 8;
  localparam int ROW_W     = PAT_BYTES + 1;
  localparam int PLEN_W    = 5;
  localparam int CNT_W     = 7;
  localparam int QDEPTH    = 2;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_TEST  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef logic [ROW_W-1:0] row_t;

  // One classified request, as queued between front and back.
  typedef struct packed {
    req_e_t              req;
    logic [STR_W-1:0]    key;
    logic [STR_W-1:0]    val;
    logic [7:0]          tchar;
    logic [PAT_W-1:0]    pat;
    logic [PLEN_W-1:0]   plen;
  } item_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // Empty-key row: position j reachable when the pattern so far is all stars.
  function automatic row_t dp_init(logic [PAT_W-1:0] pat);
    row_t r;
    r[0] = 1'b1;
    for (int j = 1; j <= PAT_BYTES; j++) begin
      r[j] = r[j-1] && (pat[(j-1)*8 +: 8] == CH_STAR);
    end
    return r;
  endfunction

  // Advance the match row by one key character; a zero byte is past the key end.
  function automatic row_t dp_step(row_t cur, logic [7:0] kc, logic [PAT_W-1:0] pat);
    row_t       nx;
    logic [7:0] p;
    nx[0] = 1'b0;
    for (int j = 1; j <= PAT_BYTES; j++) begin
      p = pat[(j-1)*8 +: 8];
      if (p == CH_STAR) begin
        nx[j] = nx[j-1] || cur[j];
      end else begin
        nx[j] = cur[j-1] && ((p == CH_QMARK) || (p == kc));
      end
    end
    return (kc == 8'd0) ? cur : nx;
  endfunction

endpackage
`default_nettype wire

### rtl/wkts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wkts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### rtl/wkts_queue.sv
// Two-entry request queue between front and back.
// Depends on wkts_pkg.
`default_nettype none
module wkts_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire wkts_pkg::item_t  push_item,
  input  wire logic             pop,
  output wkts_pkg::item_t       pop_item,
  output wkts_pkg::q_stat_t     stat
);
  import wkts_pkg::*;

  item_t      slot_r [QDEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  assign pop_item   = slot_r[rp_r];
  assign stat.full  = (cnt_r == 2'(QDEPTH));
  assign stat.valid = (cnt_r != 2'd0);
endmodule
`default_nettype wire

### rtl/wkts_front.sv
// Front end: takes input beats, trims strings and builds the query pattern.
// Depends on wkts_pkg.
`default_nettype none
module wkts_front #(
  parameter int KEY_CHARS = wkts_pkg::DEF_KEY_CHARS
) (
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   in_req_type,
  input  wire logic [63:0]  in_key_low,
  input  wire logic [55:0]  in_key_high,
  input  wire logic [63:0]  in_value_low,
  input  wire logic [55:0]  in_value_high,
  input  wire logic [7:0]   in_test_char,
  input  wire wkts_pkg::q_stat_t q_stat,
  output logic              push,
  output wkts_pkg::item_t   push_item
);
  import wkts_pkg::*;

  logic [STR_W-1:0]  key_raw, val_raw, key_n, val_n;
  logic [PAT_W-1:0]  pat;
  logic [PLEN_W-1:0] klen;
  logic              k_end, v_end, has_star;
  logic [7:0]        c;

  assign key_raw = {in_key_high, in_key_low};
  assign val_raw = {in_value_high, in_value_low};

  always_comb begin
    k_end    = 1'b0;
    v_end    = 1'b0;
    has_star = 1'b0;
    klen     = '0;
    for (int i = 0; i < STR_BYTES; i++) begin
      c = key_raw[i*8 +: 8];
      if ((c == 8'd0) || (i >= KEY_CHARS)) k_end = 1'b1;
      key_n[i*8 +: 8] = k_end ? 8'd0 : c;
      if (!k_end) klen = klen + 1'b1;
      if (!k_end && (c == CH_STAR)) has_star = 1'b1;
      c = val_raw[i*8 +: 8];
      if (c == 8'd0) v_end = 1'b1;
      val_n[i*8 +: 8] = v_end ? 8'd0 : c;
    end
    // No star: append one at the end, which turns the pattern into a prefix match.
    for (int i = 0; i < PAT_BYTES; i++) begin
      if (!has_star && (PLEN_W'(i) == klen)) begin
        pat[i*8 +: 8] = CH_STAR;
      end else if (i < STR_BYTES) begin
        pat[i*8 +: 8] = key_n[i*8 +: 8];
      end else begin
        pat[i*8 +: 8] = 8'd0;
      end
    end
  end

  assign in_stall        = q_stat.full;
  assign push            = in_valid && !q_stat.full;
  assign push_item.req   = req_e_t'(in_req_type);
  assign push_item.key   = key_n;
  assign push_item.val   = val_n;
  assign push_item.tchar = in_test_char;
  assign push_item.pat   = pat;
  assign push_item.plen  = has_star ? klen : klen + 1'b1;
endmodule
`default_nettype wire

### rtl/wkts_back.sv
// Back end: table store, character map, match pipeline and result register.
// Depends on wkts_pkg, wkts_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module wkts_back #(
  parameter int TABLE_DEPTH   = wkts_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_CHARS     = wkts_pkg::DEF_KEY_CHARS,
  parameter int CHAR_MAP_SIZE = wkts_pkg::DEF_CHAR_MAP_SIZE
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire wkts_pkg::q_stat_t q_stat,
  input  wire wkts_pkg::item_t   q_item,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [63:0]       out_match_value_low,
  output logic [55:0]       out_match_value_high,
  output logic              out_matched,
  output logic              out_char_used,
  output logic [6:0]        out_entry_count,
  output logic              out_status,
  output logic              out_last
);
  import wkts_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MW = $clog2(CHAR_MAP_SIZE);
  localparam int NS = KEY_CHARS;

  state_t               st_r, st_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt, ridx_r, ridx_nxt;
  logic [CHAR_MAP_SIZE-1:0] map_r, map_nxt;
  logic [PAT_W-1:0]     pat_r;
  logic [PLEN_W-1:0]    plen_r;
  logic                 held_v_r, held_v_nxt;
  logic [STR_W-1:0]     held_r;
  logic                 rd_v_r;
  logic [2*STR_W-1:0]   rd_data;

  logic                 st_v_r   [NS];
  row_t                 st_row_r [NS];
  logic [STR_W-1:0]     st_key_r [NS];
  logic [STR_W-1:0]     st_val_r [NS];

  logic                 adv, full, issuing, pipe_busy, drained, hit, wr_en;
  logic                 emit, e_matched, e_used, e_status, e_last;
  logic [STR_W-1:0]     e_val;
  logic [7:0]           kb;

  // Whole back end moves together when the result register can take a beat.
  assign adv  = !out_valid || !out_stall;
  assign full = (cnt_r >= CNT_W'(TABLE_DEPTH));

  assign issuing = (st_r == ST_SCAN) && (ridx_r < cnt_r);

  always_comb begin
    pipe_busy = rd_v_r;
    for (int s = 0; s < NS; s++) pipe_busy = pipe_busy | st_v_r[s];
  end
  assign drained = (st_r == ST_SCAN) && !issuing && !pipe_busy;
  assign hit     = st_v_r[NS-1] && st_row_r[NS-1][plen_r];

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    map_nxt    = map_r;
    ridx_nxt   = ridx_r;
    held_v_nxt = held_v_r;
    pop        = 1'b0;
    wr_en      = 1'b0;
    emit       = 1'b0;
    e_matched  = 1'b0;
    e_used     = 1'b0;
    e_status   = 1'b0;
    e_last     = 1'b1;
    e_val      = '0;
    kb         = 8'd0;
    if (adv) begin
      case (st_r)
        ST_IDLE: begin
          if (q_stat.valid) begin
            pop = 1'b1;
            case (q_item.req)
              REQ_ADD: begin
                emit = 1'b1;
                if (full) begin
                  e_status = 1'b1;
                end else begin
                  wr_en   = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                  for (int i = 0; i < STR_BYTES; i++) begin
                    kb = q_item.key[i*8 +: 8];
                    if ((kb != 8'd0) && ({1'b0, kb} < 9'(CHAR_MAP_SIZE))) begin
                      map_nxt[kb[MW-1:0]] = 1'b1;
                    end
                  end
                end
              end
              REQ_QUERY: begin
                st_nxt     = ST_SCAN;
                ridx_nxt   = '0;
                held_v_nxt = 1'b0;
              end
              REQ_TEST: begin
                emit   = 1'b1;
                e_used = ({1'b0, q_item.tchar} < 9'(CHAR_MAP_SIZE)) &&
                         map_r[q_item.tchar[MW-1:0]];
              end
              REQ_CLEAR: begin
                emit    = 1'b1;
                cnt_nxt = '0;
                map_nxt = '0;
              end
              default: begin
                emit = 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (issuing) ridx_nxt = ridx_r + 1'b1;
          // One match is held back so the final one can carry the last mark.
          if (hit) begin
            held_v_nxt = 1'b1;
            if (held_v_r) begin
              emit      = 1'b1;
              e_matched = 1'b1;
              e_last    = 1'b0;
              e_val     = held_r;
            end
          end else if (drained) begin
            emit       = 1'b1;
            e_matched  = held_v_r;
            e_val      = held_v_r ? held_r : '0;
            held_v_nxt = 1'b0;
            st_nxt     = ST_IDLE;
          end
        end
        default: st_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cnt_r     <= '0;
      map_r     <= '0;
      ridx_r    <= '0;
      held_v_r  <= 1'b0;
      rd_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      map_r    <= map_nxt;
      ridx_r   <= ridx_nxt;
      held_v_r <= held_v_nxt;
      if (adv) begin
        rd_v_r    <= issuing;
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (q_item.req == REQ_QUERY)) begin
      pat_r  <= q_item.pat;
      plen_r <= q_item.plen;
    end
    if (adv && hit) held_r <= st_val_r[NS-1];
    if (adv && emit) begin
      out_match_value_low  <= e_val[63:0];
      out_match_value_high <= e_val[STR_W-1:64];
      out_matched          <= e_matched;
      out_char_used        <= e_used;
      out_entry_count      <= cnt_nxt;
      out_status           <= e_status;
      out_last             <= e_last;
    end
  end

  wkts_ram #(
    .WIDTH (2 * STR_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({q_item.val, q_item.key}),
    .re    (adv),
    .raddr (ridx_r[AW-1:0]),
    .rdata (rd_data)
  );

  // Match pipeline: stage s consumes key character s.
  for (genvar s = 0; s < NS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[s] <= 1'b0;
      end else if (adv) begin
        st_v_r[s] <= (s == 0) ? rd_v_r : st_v_r[(s == 0) ? 0 : s-1];
      end
    end
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          st_row_r[s] <= dp_step(dp_init(pat_r), rd_data[7:0], pat_r);
          st_key_r[s] <= rd_data[STR_W-1:0];
          st_val_r[s] <= rd_data[2*STR_W-1:STR_W];
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          st_row_r[s] <= dp_step(st_row_r[s-1], st_key_r[s-1][s*8 +: 8], pat_r);
          st_key_r[s] <= st_key_r[s-1];
          st_val_r[s] <= st_val_r[s-1];
        end
      end
    end
  end

  `WK_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
  `WK_ASSERT_IMP(a_match_scan, out_valid && out_matched && !$past(out_valid && out_stall),
                 $past(st_r) == ST_SCAN, "match result outside a scan")
  `WK_ASSERT_IMP(a_full_reply, out_valid && out_status, !out_matched && out_last,
                 "table-full reply must be a lone unmatched beat")
endmodule
`default_nettype wire

### rtl/wildcard_key_table_search.sv
// Add, test and clear: accepted into the queue, popped by the back end, answered from the result register.
// Query: the store is read one entry a cycle while the result register is not stalled,
//   so the RAM read port sets the scan length; matches stream out as the pipeline fills.
// Throughput: add, test, clear one per cycle while out_stall is low; a query holds the back
//   end until its scan has drained; a two-entry queue takes input until it is full.
// Reset (rst_n low, synchronous): table empty, character map clear, no beat pending.
`default_nettype none
module wildcard_key_table_search #(
  parameter int TABLE_DEPTH   = wkts_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_CHARS     = wkts_pkg::DEF_KEY_CHARS,
  parameter int CHAR_MAP_SIZE = wkts_pkg::DEF_CHAR_MAP_SIZE
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [63:0] in_key_low,
  input  wire logic [55:0] in_key_high,
  input  wire logic [63:0] in_value_low,
  input  wire logic [55:0] in_value_high,
  input  wire logic [7:0]  in_test_char,
  // result beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_match_value_low,
  output logic [55:0]      out_match_value_high,
  output logic             out_matched,
  output logic             out_char_used,
  output logic [6:0]       out_entry_count,
  output logic             out_status,
  output logic             out_last
);
  import wkts_pkg::*;

  q_stat_t q_stat;
  item_t   push_item, pop_item;
  logic    push, pop;

  // Front trims key/value at their first zero byte (the key also at KEY_CHARS) and builds the glob pattern.
  wkts_front #(
    .KEY_CHARS (KEY_CHARS)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_key_low    (in_key_low),
    .in_key_high   (in_key_high),
    .in_value_low  (in_value_low),
    .in_value_high (in_value_high),
    .in_test_char  (in_test_char),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  // Decouples acceptance from the scan in the back end.
  wkts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  // Back end owns the table, the map and the result register.
  wkts_back #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .KEY_CHARS     (KEY_CHARS),
    .CHAR_MAP_SIZE (CHAR_MAP_SIZE)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_stat               (q_stat),
    .q_item               (pop_item),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_match_value_low  (out_match_value_low),
    .out_match_value_high (out_match_value_high),
    .out_matched          (out_matched),
    .out_char_used        (out_char_used),
    .out_entry_count      (out_entry_count),
    .out_status           (out_status),
    .out_last             (out_last)
  );
endmodule
`default_nettype wire

### test/wildcard_key_table_search_tb.sv
// Self-checking bench for wildcard_key_table_search: adds, glob queries, char tests, clears.
// Predicts each result beat from its own table model; depends on wkts_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module wildcard_key_table_search_tb;
  import wkts_pkg::*;

  localparam int DEPTH     = 64;
  localparam int KCHARS    = 15;
  localparam int MAP_SIZE  = 256;
  localparam int CYC_LIMIT = 1500000;

  typedef struct packed {
    logic [63:0] vlo;
    logic [55:0] vhi;
    logic        matched;
    logic        used;
    logic [6:0]  count;
    logic        status;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_ADD;
  logic [63:0] in_key_low = '0;
  logic [55:0] in_key_high = '0;
  logic [63:0] in_value_low = '0;
  logic [55:0] in_value_high = '0;
  logic [7:0]  in_test_char = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [63:0] out_match_value_low;
  logic [55:0] out_match_value_high;
  logic        out_matched, out_char_used, out_status, out_last;
  logic [6:0]  out_entry_count;

  wildcard_key_table_search dut (.*);

  always #10 clk = ~clk;

  // model state
  logic [119:0] tbl_key [DEPTH];
  logic [119:0] tbl_val [DEPTH];
  int           tbl_used;
  logic [255:0] char_map;
  result_t      pending_results[$];

  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 0;      // no idling on either side
  int  idle_pct = 10;

  // truncate at first zero byte or limit
  function automatic logic [119:0] trim_str(logic [119:0] s, int limit, output int len);
    logic [119:0] r = '0;
    bit ended = 0;
    len = 0;
    for (int i = 0; i < 15; i++) begin
      if (s[i*8 +: 8] == 8'd0 || i >= limit) ended = 1;
      if (!ended) begin
        r[i*8 +: 8] = s[i*8 +: 8];
        len++;
      end
    end
    return r;
  endfunction

  function automatic bit glob_hit(logic [119:0] k, int klen, logic [127:0] p, int plen);
    bit cur [17];
    bit nxt [17];
    logic [7:0] pc;
    cur[0] = 1;
    for (int j = 1; j <= plen; j++) cur[j] = cur[j-1] && p[(j-1)*8 +: 8] == CH_STAR;
    for (int i = 0; i < klen; i++) begin
      nxt[0] = 0;
      for (int j = 1; j <= plen; j++) begin
        pc = p[(j-1)*8 +: 8];
        if (pc == CH_STAR) nxt[j] = nxt[j-1] || cur[j];
        else nxt[j] = cur[j-1] && (pc == CH_QMARK || pc == k[i*8 +: 8]);
      end
      cur = nxt;
    end
    return cur[plen];
  endfunction

  function automatic result_t mk_res(logic [119:0] v, bit m, bit u, bit st, bit l);
    result_t r;
    r.vlo = v[63:0]; r.vhi = v[119:64]; r.matched = m; r.used = u;
    r.count = tbl_used[6:0]; r.status = st; r.last = l;
    return r;
  endfunction

  // compute expected beats for one request and update model state
  task automatic predict_table_op(logic [1:0] rq, logic [119:0] key, logic [119:0] val,
                                  logic [7:0] tc);
    logic [119:0] ks, vs;
    logic [127:0] pat;
    int klen, vlen, slen, hits;
    bit star;
    result_t r;
    case (rq)
      REQ_ADD: begin
        if (tbl_used >= DEPTH) pending_results.push_back(mk_res('0, 0, 0, 1, 1));
        else begin
          ks = trim_str(key, KCHARS, klen);
          vs = trim_str(val, 15, vlen);
          tbl_key[tbl_used] = ks;
          tbl_val[tbl_used] = vs;
          for (int i = 0; i < klen; i++)
            if (ks[i*8 +: 8] < MAP_SIZE) char_map[ks[i*8 +: 8]] = 1'b1;
          tbl_used++;
          pending_results.push_back(mk_res('0, 0, 0, 0, 1));
        end
      end
      REQ_QUERY: begin
        ks = trim_str(key, KCHARS, klen);
        pat = {8'd0, ks};
        star = 0;
        for (int i = 0; i < klen; i++) if (ks[i*8 +: 8] == CH_STAR) star = 1;
        if (!star) begin
          pat[klen*8 +: 8] = CH_STAR;
          klen++;
        end
        hits = 0;
        for (int e = 0; e < tbl_used; e++) begin
          ks = trim_str(tbl_key[e], KCHARS, slen);
          if (glob_hit(ks, slen, pat, klen)) begin
            pending_results.push_back(mk_res(tbl_val[e], 1, 0, 0, 0));
            hits++;
          end
        end
        if (hits == 0) pending_results.push_back(mk_res('0, 0, 0, 0, 1));
        else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      REQ_TEST: pending_results.push_back(mk_res('0, 0, tc < MAP_SIZE && char_map[tc], 0, 1));
      default: begin
        tbl_used = 0;
        char_map = '0;
        pending_results.push_back(mk_res('0, 0, 0, 0, 1));
      end
    endcase
  endtask

  // send one request beat; inputs move on the falling edge, valid drops only to idle
  task automatic send_req(logic [1:0] rq, logic [119:0] key, logic [119:0] val,
                          logic [7:0] tc);
    while (!quiet && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rq;
    {in_key_high, in_key_low}     <= key;
    {in_value_high, in_value_low} <= val;
    in_test_char  <= tc;
    predict_table_op(rq, key, val, tc);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // string of up to maxlen chars drawn from a small alphabet (so globs hit)
  function automatic logic [119:0] rand_word(int maxlen, bit wild);
    logic [119:0] s = '0;
    int n = $urandom_range(maxlen);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      if (wild && pick == 0) s[i*8 +: 8] = CH_STAR;
      else if (wild && pick == 1) s[i*8 +: 8] = CH_QMARK;
      else s[i*8 +: 8] = 8'(8'h61 + $urandom_range(3));
    end
    return s;
  endfunction

  function automatic logic [119:0] rand_bits();
    return 120'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  // wait for all beats, then a settling pause
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    // empty table query, empty key, all-star pattern, bytes beyond a zero
    send_req(REQ_QUERY, "", '0, 0);
    send_req(REQ_ADD, '0, {120{1'b1}}, 0);
    send_req(REQ_ADD, {8'h7A, 8'h00, 8'h62, 8'h61}, "v1", 0);
    send_req(REQ_ADD, {120{1'b1}}, '0, 0);
    send_req(REQ_ADD, "ab?*", "v2", 0);
    send_req(REQ_QUERY, "*", '0, 0);
    send_req(REQ_QUERY, "a", '0, 0);
    send_req(REQ_QUERY, "a?", '0, 0);
    send_req(REQ_QUERY, "*b", '0, 0);
    send_req(REQ_QUERY, "zz", '0, 0);
    send_req(REQ_QUERY, {120{1'b1}}, '0, 0);
    send_req(REQ_TEST, '0, '0, 8'h61);
    send_req(REQ_TEST, '0, '0, 8'hFF);
    send_req(REQ_TEST, '0, '0, 8'h00);
    send_req(REQ_TEST, '0, '0, 8'h7A);
    send_req(REQ_CLEAR, '0, '0, 0);
    send_req(REQ_TEST, '0, '0, 8'h61);
    send_req(REQ_QUERY, "", '0, 0);
    drain();
  endtask

  // fill past capacity, query a full table
  task automatic test_full_table();
    quiet = 1;
    for (int i = 0; i < DEPTH + 2; i++) send_req(REQ_ADD, rand_word(4, 0), rand_bits(), 0);
    quiet = 0;
    send_req(REQ_QUERY, "*", '0, 0);
    send_req(REQ_QUERY, "?", '0, 0);
    send_req(REQ_CLEAR, '0, '0, 0);
    drain();
  endtask

  task automatic test_random();
    int pick;
    for (int i = 0; i < 280; i++) begin
      quiet = (i >= 150 && i < 220);
      pick = $urandom_range(99);
      if (pick < 2) send_req(REQ_CLEAR, rand_bits(), rand_bits(), 8'($urandom));
      else if (pick < 40)
        send_req(REQ_ADD, (pick < 5) ? rand_bits() : rand_word(8, 0), rand_bits(),
                 8'($urandom));
      else if (pick < 80)
        send_req(REQ_QUERY, (pick < 43) ? rand_bits() : rand_word(6, 1), rand_bits(),
                 8'($urandom));
      else
        send_req(REQ_TEST, rand_bits(), rand_bits(),
                 (pick < 90) ? 8'(8'h61 + $urandom_range(3)) : 8'($urandom));
    end
    quiet = 0;
    drain();
  endtask

  // result sink: random stall, compare on accepted beats
  always @(negedge clk) begin
    if (rst_n) out_stall <= !quiet && ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    result_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_match_value_low !== want.vlo) begin
          $error("match_value_low exp %h got %h", want.vlo, out_match_value_low); errors++;
        end
        if (out_match_value_high !== want.vhi) begin
          $error("match_value_high exp %h got %h", want.vhi, out_match_value_high); errors++;
        end
        if (out_matched !== want.matched) begin
          $error("matched exp %b got %b", want.matched, out_matched); errors++;
        end
        if (out_char_used !== want.used) begin
          $error("char_used exp %b got %b", want.used, out_char_used); errors++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count exp %0d got %0d", want.count, out_entry_count); errors++;
        end
        if (out_status !== want.status) begin
          $error("status exp %b got %b", want.status, out_status); errors++;
        end
        if (out_last !== want.last) begin
          $error("last exp %b got %b", want.last, out_last); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYC_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    tbl_used = 0;
    char_map = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_table();
    test_random();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
